// ===== sv/ptc_pkg.sv =====
// Shared widths, constants and register codes of the pressure and temperature compensation block.
package ptc_pkg;

	// Field widths at the ports
	localparam int RAW_W  = 24;
	localparam int COEF_W = 16;
	localparam int TOUT_W = 19;
	localparam int POUT_W = 26;
	localparam int IDX_W  = 3;

	// Internal datapath widths
	localparam int DT_W   = 25;  // dT, signed
	localparam int TEMP_W = 20;  // first-order TEMP, signed
	localparam int CP_W   = 42;  // coefficient times dT
	localparam int DSQ_W  = 50;  // dT squared
	localparam int SQ_W   = 40;  // squared temperature offsets
	localparam int ACC_W  = 40;  // OFF and SENS
	localparam int LO_W   = 20;  // low slice of SENS for the split product
	localparam int PLO_W  = RAW_W + LO_W;
	localparam int PHI_W  = RAW_W + 1 + ACC_W - LO_W;
	localparam int MUL_W  = PHI_W + LO_W;

	localparam int NUM_STAGES = 9;

	// Scaling shifts
	localparam int TEMP_SHIFT  = 23;
	localparam int T2_SHIFT    = 31;
	localparam int TREF_SHIFT  = 8;
	localparam int OFF_SHIFT   = 16;
	localparam int SENS_SHIFT  = 15;
	localparam int TCO_SHIFT   = 7;
	localparam int TCS_SHIFT   = 8;
	localparam int SQ8_SHIFT   = 3;
	localparam int PROD_SHIFT  = 21;
	localparam int PRES_SHIFT  = 15;

	// Temperature thresholds in hundredths of a degree
	localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -20'sd1500;
	localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 20'sd4500;

	// Calibration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_SENS     = 3'd0,
		REG_OFFSET   = 3'd1,
		REG_TCS      = 3'd2,
		REG_TCO      = 3'd3,
		REG_TREF     = 3'd4,
		REG_TEMPSENS = 3'd5
	} ptc_reg_t;

endpackage

// ===== sv/ptc_if.sv =====
// Handshake channel interfaces for samples, results and calibration writes.
interface ptc_sample_if;
	import ptc_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;
	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_result_if;
	import ptc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TOUT_W-1:0] temperature_centi;
	logic signed [POUT_W-1:0] pressure_centi;
	modport source (output valid, output temperature_centi, output pressure_centi, input ready);
	modport sink   (input valid, input temperature_centi, input pressure_centi, output ready);
endinterface

interface ptc_cfg_if;
	import ptc_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [COEF_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pressure_temp_compensation.sv =====
// Second-order barometric pressure and temperature compensation pipeline.
//
// Takes one raw pressure/temperature pair per transfer and returns the compensated
// temperature and pressure in hundredths, one result per sample, in order. The block
// is a nine-stage pipeline that accepts a sample every cycle unless a stalled result
// side has left every stage full. The pipeline depth is set by the chain of
// products (coefficient times dT, squared temperature offsets, then the 65-bit
// pressure product split into two partial products and summed in a stage
// of its own). Each stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up under a stalled output and sample.ready stays
// high while any stage is free. The six calibration words are written through cfg,
// which is always ready; write them only while no sample is in flight. Writes to an
// index past the sixth register are dropped.
module pressure_temp_compensation (
	input  logic         clk,
	input  logic         arst_n,
	ptc_sample_if.sink   sample,
	ptc_result_if.source result,
	ptc_cfg_if.sink      cfg
);
	import ptc_pkg::*;

	// Calibration registers
	logic [COEF_W-1:0] coef_sens_q, coef_offset_q, coef_tcs_q;
	logic [COEF_W-1:0] coef_tco_q, coef_tref_q, coef_tempsens_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_sens_q     <= '0;
			coef_offset_q   <= '0;
			coef_tcs_q      <= '0;
			coef_tco_q      <= '0;
			coef_tref_q     <= '0;
			coef_tempsens_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SENS:     coef_sens_q     <= cfg.data;
				REG_OFFSET:   coef_offset_q   <= cfg.data;
				REG_TCS:      coef_tcs_q      <= cfg.data;
				REG_TCO:      coef_tco_q      <= cfg.data;
				REG_TREF:     coef_tref_q     <= cfg.data;
				REG_TEMPSENS: coef_tempsens_q <= cfg.data;
				default:      ; // drop writes past the last register
			endcase
		end
	end

	// Stage control: a stage advances when it is empty or the next one advances
	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] adv;

	always_comb begin
		adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || result.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign sample.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) begin
				valid_q[0] <= sample.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Stage 1: register the sample and form dT
	logic signed [DT_W-1:0] dt_c;
	logic signed [DT_W-1:0] dt_s1;
	logic [RAW_W-1:0]       d1_s1;

	assign dt_c = $signed({1'b0, sample.raw_temperature})
		- $signed({1'b0, coef_tref_q, {TREF_SHIFT{1'b0}}});

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dt_s1 <= dt_c;
			d1_s1 <= sample.raw_pressure;
		end
	end

	// Stage 2: coefficient products and dT squared
	logic signed [CP_W-1:0]  p_tc_s2, p_tco_s2, p_tcs_s2;
	logic signed [DSQ_W-1:0] p_dd_s2;
	logic [RAW_W-1:0]        d1_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			p_tc_s2  <= dt_s1 * $signed({1'b0, coef_tempsens_q});
			p_tco_s2 <= dt_s1 * $signed({1'b0, coef_tco_q});
			p_tcs_s2 <= dt_s1 * $signed({1'b0, coef_tcs_q});
			p_dd_s2  <= dt_s1 * dt_s1;
			d1_s2    <= d1_s1;
		end
	end

	// Stage 3: first-order TEMP, T2, and the first-order parts of OFF and SENS
	logic signed [TEMP_W-1:0] temp_c;
	logic signed [ACC_W-1:0]  off1_c, sens1_c;
	logic signed [TEMP_W-1:0] temp_s3;
	logic [TOUT_W-1:0]        t2_s3;
	logic signed [ACC_W-1:0]  off1_s3, sens1_s3;
	logic [RAW_W-1:0]         d1_s3;

	assign temp_c  = $signed(TEMP_W'(p_tc_s2 >>> TEMP_SHIFT)) + TEMP_REF;
	assign off1_c  = $signed({{(ACC_W-COEF_W-OFF_SHIFT){1'b0}}, coef_offset_q,
		{OFF_SHIFT{1'b0}}}) + $signed(ACC_W'(p_tco_s2 >>> TCO_SHIFT));
	assign sens1_c = $signed({{(ACC_W-COEF_W-SENS_SHIFT){1'b0}}, coef_sens_q,
		{SENS_SHIFT{1'b0}}}) + $signed(ACC_W'(p_tcs_s2 >>> TCS_SHIFT));

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			temp_s3  <= temp_c;
			t2_s3    <= TOUT_W'(p_dd_s2 >>> T2_SHIFT);
			off1_s3  <= off1_c;
			sens1_s3 <= sens1_c;
			d1_s3    <= d1_s2;
		end
	end

	// Stage 4: temperature band flags, squared offsets, final temperature
	logic                     lo_c;
	logic signed [TEMP_W-1:0] da_c, db_c, tout_c;
	logic signed [SQ_W-1:0]   sq_a_s4, sq_b_s4;
	logic                     lo_s4, vlo_s4, hi_s4;
	logic signed [TEMP_W-1:0] tout_s4;
	logic signed [ACC_W-1:0]  off1_s4, sens1_s4;
	logic [RAW_W-1:0]         d1_s4;

	assign lo_c   = temp_s3 < TEMP_REF;
	assign da_c   = temp_s3 - TEMP_REF;
	assign db_c   = lo_c ? (temp_s3 - TEMP_LOW) : (temp_s3 - TEMP_HIGH);
	assign tout_c = lo_c ? (temp_s3 - $signed({1'b0, t2_s3})) : temp_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			sq_a_s4  <= da_c * da_c;
			sq_b_s4  <= db_c * db_c;
			lo_s4    <= lo_c;
			vlo_s4   <= temp_s3 < TEMP_LOW;
			hi_s4    <= temp_s3 > TEMP_HIGH;
			tout_s4  <= tout_c;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			d1_s4    <= d1_s3;
		end
	end

	// Stage 5: second-order corrections OFF2 and SENS2
	logic signed [SQ_W-1:0]   qa_c, qb_c;
	logic signed [ACC_W-1:0]  off2_c, sens2_c;
	logic signed [ACC_W-1:0]  off2_s5, sens2_s5, off1_s5, sens1_s5;
	logic signed [TEMP_W-1:0] tout_s5;
	logic [RAW_W-1:0]         d1_s5;

	assign qa_c = sq_a_s4 >>> SQ8_SHIFT;
	assign qb_c = sq_b_s4 >>> SQ8_SHIFT;

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (lo_s4) begin
			off2_c  = sq_a_s4 + (sq_a_s4 <<< 1);
			sens2_c = (qa_c <<< SQ8_SHIFT) - qa_c;
			if (vlo_s4) begin
				sens2_c = sens2_c + (sq_b_s4 <<< 1);
			end
		end else if (hi_s4) begin
			sens2_c = -qb_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			tout_s5  <= tout_s4;
			d1_s5    <= d1_s4;
		end
	end

	// Stage 6: OFF and SENS
	logic signed [ACC_W-1:0]  off_s6, sens_s6;
	logic signed [TEMP_W-1:0] tout_s6;
	logic [RAW_W-1:0]         d1_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			off_s6  <= off1_s5 - off2_s5;
			sens_s6 <= sens1_s5 - sens2_s5;
			tout_s6 <= tout_s5;
			d1_s6   <= d1_s5;
		end
	end

	// Stage 7: D1 times SENS as two partial products
	logic [PLO_W-1:0]         pp_lo_s7;
	logic signed [PHI_W-1:0]  pp_hi_s7;
	logic signed [ACC_W-1:0]  off_s7;
	logic signed [TEMP_W-1:0] tout_s7;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			pp_lo_s7 <= PLO_W'(d1_s6) * PLO_W'(sens_s6[LO_W-1:0]);
			pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_s6[ACC_W-1:LO_W]);
			off_s7   <= off_s6;
			tout_s7  <= tout_s6;
		end
	end

	// Stage 8: sum the partial products
	logic signed [MUL_W-1:0]  prod_s8;
	logic signed [ACC_W-1:0]  off_s8;
	logic signed [TEMP_W-1:0] tout_s8;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			prod_s8 <= $signed({pp_hi_s7, {LO_W{1'b0}}})
				+ $signed({{(MUL_W-PLO_W){1'b0}}, pp_lo_s7});
			off_s8  <= off_s7;
			tout_s8 <= tout_s7;
		end
	end

	// Stage 9: scale, remove OFF and scale again into the output register
	localparam int X_W = MUL_W - PROD_SHIFT;
	localparam int Y_W = X_W + 1;

	logic signed [X_W-1:0]    x_c;
	logic signed [Y_W-1:0]    y_c;
	logic signed [POUT_W-1:0] pres_s9;
	logic signed [TOUT_W-1:0] tout_s9;

	assign x_c = $signed(X_W'(prod_s8 >>> PROD_SHIFT));
	assign y_c = $signed({x_c[X_W-1], x_c})
		- $signed({{(Y_W-ACC_W){off_s8[ACC_W-1]}}, off_s8});

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			pres_s9 <= $signed(POUT_W'(y_c >>> PRES_SHIFT));
			tout_s9 <= $signed(tout_s8[TOUT_W-1:0]);
		end
	end

	assign result.valid             = valid_q[NUM_STAGES-1];
	assign result.temperature_centi = tout_s9;
	assign result.pressure_centi    = pres_s9;

endmodule

// ===== sv/ptc_checker.sv =====
// Port-level assertion checker for the compensation block, with its bind.
module ptc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             sample_valid,
	input logic                             sample_ready,
	input logic                             result_valid,
	input logic                             result_ready,
	input logic signed [ptc_pkg::TOUT_W-1:0] temperature_centi,
	input logic signed [ptc_pkg::POUT_W-1:0] pressure_centi
);
	import ptc_pkg::*;

	logic sample_xfer;
	assign sample_xfer = sample_valid && sample_ready;

	// Hold no result while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	// Hold a stalled result and its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
		result_valid && $stable(temperature_centi) && $stable(pressure_centi))
		else $error("stalled result changed");

	// Accept samples whenever the output register is empty
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("sample refused with empty output");

	// Deliver a sample after the pipeline depth when the sink keeps ready high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_xfer ##1 result_ready ##1 result_ready ##1 result_ready
		##1 result_ready ##1 result_ready ##1 result_ready ##1 result_ready
		##1 result_ready |=> result_valid)
		else $error("result missing after pipeline depth");

endmodule

bind pressure_temp_compensation ptc_checker u_ptc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.sample_valid      (sample.valid),
	.sample_ready      (sample.ready),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.temperature_centi (result.temperature_centi),
	.pressure_centi    (result.pressure_centi)
);
